FILE: rtl/uart_tx_frame_serializer_core_defines.svh
`ifndef UART_TX_FRAME_SERIALIZER_CORE_DEFINES_SVH
`define UART_TX_FRAME_SERIALIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UTS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/uts_pkg.sv
`default_nettype none
package uts_pkg;

   localparam int DATA_W     = 9;
   localparam int COUNT_W    = 4;
   localparam int HOLD_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_WORD_NINE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARITY_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TWO_STOP      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_CYCLES = 2'd3;

   localparam logic [1:0] PAR_NONE = 2'd0;
   localparam logic [1:0] PAR_ODD  = 2'd1;
   localparam logic [1:0] PAR_EVEN = 2'd2;

   localparam logic [HOLD_W-1:0] SYMBOL_CYCLES_RESET = 16'd833;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DATA,
      ST_PARITY,
      ST_STOP,
      ST_STOP_LAST
   } state_type;

   typedef enum logic [2:0] {
      SYM_START,
      SYM_DATA,
      SYM_PARITY,
      SYM_STOP,
      SYM_STOP_LAST
   } sym_type;

   typedef struct packed {
      logic    load;
      logic    emit;
      sym_type kind;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic data_last;
      logic parity_on;
      logic two_stop;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/uts_req_if.sv
`default_nettype none
interface uts_req_if;
   import uts_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/uts_rsp_if.sv
`default_nettype none
interface uts_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic last_symbol;

   modport source (output valid, output line_level, output last_symbol, input ready);
   modport sink (input valid, input line_level, input last_symbol, output ready);
endinterface
`default_nettype wire

FILE: rtl/uts_controller.sv
`default_nettype none
module uts_controller (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  uts_pkg::status_type status,
   output uts_pkg::cmd_type    cmd
);
   import uts_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.emit  = 1'b0;
      cmd.kind  = SYM_START;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = SYM_START;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = SYM_DATA;
               if (status.data_last) begin
                  if (status.parity_on) begin
                     state_in = ST_PARITY;
                  end else if (status.two_stop) begin
                     state_in = ST_STOP;
                  end else begin
                     state_in = ST_STOP_LAST;
                  end
               end
            end
         end
         ST_PARITY: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = SYM_PARITY;
               state_in = status.two_stop ? ST_STOP : ST_STOP_LAST;
            end
         end
         ST_STOP: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = SYM_STOP;
               state_in = ST_STOP_LAST;
            end
         end
         ST_STOP_LAST: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = SYM_STOP_LAST;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/uts_datapath.sv
`default_nettype none
module uts_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire  [uts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [uts_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire  [uts_pkg::DATA_W-1:0]         req_data,
   input  uts_pkg::cmd_type                   cmd,
   output uts_pkg::status_type                status,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic                               rsp_line_level,
   output logic                               rsp_last_symbol
);
   import uts_pkg::*;

   logic              word_nine_ff, word_nine_in;
   logic [1:0]        parity_mode_ff, parity_mode_in;
   logic              two_stop_ff, two_stop_in;
   logic [HOLD_W-1:0] symbol_cycles_ff, symbol_cycles_in;

   logic [DATA_W-1:0]  shift_ff, shift_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               parity_ff, parity_in;

   logic              out_full_ff, out_full_in;
   logic              level_ff, level_in;
   logic              last_ff, last_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;

   logic               parity_on;
   logic [COUNT_W-1:0] data_bits;
   logic               rsp_xfer;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_nine_ff     <= 1'b0;
         parity_mode_ff   <= PAR_NONE;
         two_stop_ff      <= 1'b0;
         symbol_cycles_ff <= SYMBOL_CYCLES_RESET;
         shift_ff         <= '0;
         count_ff         <= '0;
         parity_ff        <= 1'b0;
         out_full_ff      <= 1'b0;
         hold_ff          <= '0;
      end else begin
         word_nine_ff     <= word_nine_in;
         parity_mode_ff   <= parity_mode_in;
         two_stop_ff      <= two_stop_in;
         symbol_cycles_ff <= symbol_cycles_in;
         shift_ff         <= shift_in;
         count_ff         <= count_in;
         parity_ff        <= parity_in;
         out_full_ff      <= out_full_in;
         hold_ff          <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      last_ff  <= last_in;
   end

   assign parity_on = (parity_mode_ff == PAR_ODD) || (parity_mode_ff == PAR_EVEN);
   assign data_bits = (word_nine_ff ? COUNT_W'(9) : COUNT_W'(8)) - COUNT_W'(parity_on);

   assign rsp_valid       = out_full_ff && (hold_ff <= HOLD_W'(1));
   assign rsp_line_level  = level_ff;
   assign rsp_last_symbol = last_ff;
   assign rsp_xfer        = rsp_valid && rsp_ready;

   assign status.slot_free = !out_full_ff || rsp_xfer;
   assign status.data_last = (count_ff == (data_bits - COUNT_W'(1)));
   assign status.parity_on = parity_on;
   assign status.two_stop  = two_stop_ff;

   always_comb begin
      word_nine_in     = word_nine_ff;
      parity_mode_in   = parity_mode_ff;
      two_stop_in      = two_stop_ff;
      symbol_cycles_in = symbol_cycles_ff;
      shift_in         = shift_ff;
      count_in         = count_ff;
      parity_in        = parity_ff;
      out_full_in      = out_full_ff;
      level_in         = level_ff;
      last_in          = last_ff;
      hold_in          = hold_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_WORD_NINE:     word_nine_in     = csr_wdata[0];
            CSR_PARITY_MODE:   parity_mode_in   = csr_wdata[1:0];
            CSR_TWO_STOP:      two_stop_in      = csr_wdata[0];
            CSR_SYMBOL_CYCLES: symbol_cycles_in = csr_wdata[HOLD_W-1:0];
            default:           word_nine_in     = word_nine_ff;
         endcase
      end

      if (cmd.load) begin
         shift_in  = req_data;
         count_in  = '0;
         parity_in = 1'b0;
      end

      if (rsp_xfer) begin
         out_full_in = 1'b0;
      end

      if (hold_ff > HOLD_W'(1)) begin
         hold_in = hold_ff - HOLD_W'(1);
      end

      if (cmd.emit) begin
         out_full_in = 1'b1;
         hold_in     = symbol_cycles_ff;
         last_in     = 1'b0;
         unique case (cmd.kind)
            SYM_START: begin
               level_in = 1'b0;
            end
            SYM_DATA: begin
               level_in  = shift_ff[0];
               shift_in  = shift_ff >> 1;
               parity_in = parity_ff ^ shift_ff[0];
               count_in  = count_ff + COUNT_W'(1);
            end
            SYM_PARITY: begin
               level_in = (parity_mode_ff == PAR_ODD) ? ~parity_ff : parity_ff;
            end
            SYM_STOP: begin
               level_in = 1'b1;
            end
            SYM_STOP_LAST: begin
               level_in = 1'b1;
               last_in  = 1'b1;
            end
            default: begin
               level_in = 1'b1;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/uart_tx_frame_serializer_core.sv
// Sequence: a taken character is loaded into the shift register; each symbol is then
// written to the output register as its slot frees and offered once the hold runs down.
// Throughput: one frame of 10 to 12 symbols per character, each symbol paced by the hold
// counter; a new character is taken once the final stop symbol is in the output register.
// Reset (synchronous, active high) restores the register defaults, 8 bits, no parity,
// one stop, a symbol_cycles value of 833, and empties the output register.
`default_nettype none
module uart_tx_frame_serializer_core (
   input  wire                            clock,
   input  wire                            reset,
   uts_req_if.sink                        req_bus,
   uts_rsp_if.source                      rsp_bus,
   input  wire                            csr_we,
   input  wire [uts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [uts_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import uts_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_bus.ready = req_ready;

   uts_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   uts_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_data        (req_bus.data),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_line_level  (rsp_bus.line_level),
      .rsp_last_symbol (rsp_bus.last_symbol)
   );
endmodule
`default_nettype wire

FILE: rtl/uts_checker.sv
`default_nettype none
`include "uart_tx_frame_serializer_core_defines.svh"
module uts_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire rsp_line_level,
   input wire rsp_last_symbol
);
   `UTS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_line_level) && $stable(rsp_last_symbol), "Stalled symbol changed or was dropped.")
   `UTS_ASSERT_IMP(a_last_is_stop, clock, reset, rsp_valid && rsp_last_symbol, rsp_line_level, "Final symbol of a frame is not a high stop symbol.")
   `UTS_ASSERT_NXT(a_one_frame, clock, reset, req_valid && req_ready, !req_ready, "A new character was taken while its frame had just begun.")
   `UTS_ASSERT_NXT(a_ready_drops_at_xfer, clock, reset, req_ready && req_valid, !(req_valid && req_ready), "Two characters transferred on consecutive cycles.")
endmodule

bind uart_tx_frame_serializer_core uts_checker u_uts_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_line_level  (rsp_bus.line_level),
   .rsp_last_symbol (rsp_bus.last_symbol)
);
`default_nettype wire

FILE: verif/uart_tx_frame_serializer_core_tb.sv
`default_nettype none
module uart_tx_frame_serializer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import uts_pkg::*;

   localparam logic [1:0] PAR_RESERVED = 2'd3;
   localparam int QUIET_LIMIT = 200000;
   localparam int PRESSURE_CYCLES = 400;
   localparam int RANDOM_PHASES = 12;
   localparam int CHARS_PER_PHASE = 28;

   typedef struct packed {
      logic line_level;
      logic last_symbol;
   } symbol_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   uts_req_if req_bus ();
   uts_rsp_if rsp_bus ();

   uart_tx_frame_serializer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic              cfg_word_nine;
   logic [1:0]        cfg_parity;
   logic              cfg_two_stop;
   logic [HOLD_W-1:0] cfg_hold;

   logic [DATA_W-1:0] chars_pending[$];
   symbol_type        expected_symbols[$];

   int  chars_queued = 0;
   int  chars_taken = 0;
   int  symbols_checked = 0;
   int  mismatches = 0;
   int  settings_used = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  rsp_stall = 0;
   int  pressure_left = 0;
   bit  pressure_armed = 0;
   bit  no_idle = 0;
   logic req_took;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic predict_frame(input logic [DATA_W-1:0] ch);
      logic parity_on;
      logic ones;
      int   nbits;
      parity_on = (cfg_parity == PAR_ODD) || (cfg_parity == PAR_EVEN);
      nbits = (cfg_word_nine ? 9 : 8) - (parity_on ? 1 : 0);
      ones = 1'b0;
      expected_symbols.push_back(symbol_type'({1'b0, 1'b0}));
      for (int i = 0; i < nbits; i++) begin
         ones ^= ch[i];
         expected_symbols.push_back(symbol_type'({ch[i], 1'b0}));
      end
      if (cfg_parity == PAR_ODD) begin
         expected_symbols.push_back(symbol_type'({~ones, 1'b0}));
      end else if (cfg_parity == PAR_EVEN) begin
         expected_symbols.push_back(symbol_type'({ones, 1'b0}));
      end
      if (cfg_two_stop) begin
         expected_symbols.push_back(symbol_type'({1'b1, 1'b0}));
      end
      expected_symbols.push_back(symbol_type'({1'b1, 1'b1}));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_WORD_NINE:     cfg_word_nine = val[0];
         CSR_PARITY_MODE:   cfg_parity = val[1:0];
         CSR_TWO_STOP:      cfg_two_stop = val[0];
         CSR_SYMBOL_CYCLES: cfg_hold = val;
         default: ;
      endcase
   endtask

   // Upper bits of the narrow registers carry noise, which the block must drop.
   task automatic apply_config(input logic w, input logic [1:0] p, input logic s,
                               input logic [HOLD_W-1:0] h);
      write_reg(CSR_WORD_NINE, {15'($urandom), w});
      write_reg(CSR_PARITY_MODE, {14'($urandom), p});
      write_reg(CSR_TWO_STOP, {15'($urandom), s});
      write_reg(CSR_SYMBOL_CYCLES, h);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic queue_char(input logic [DATA_W-1:0] ch);
      chars_pending.push_back(ch);
      chars_queued++;
   endtask

   task automatic drain();
      while (chars_taken != chars_queued || expected_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_took) begin
         req_bus.valid <= 1'b1;
      end else if (send_gap > 0) begin
         req_bus.valid <= 1'b0;
         send_gap--;
      end else if (chars_pending.size() != 0) begin
         req_bus.valid <= 1'b1;
         req_bus.data <= chars_pending.pop_front();
         send_gap = idle_gap();
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (pressure_armed) begin
         pressure_left = PRESSURE_CYCLES;
         pressure_armed = 0;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (pressure_left > 0) begin
         rsp_bus.ready <= 1'b0;
         pressure_left--;
      end else if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_stall = idle_gap();
      end
   end

   always @(posedge clock) begin
      symbol_type got;
      symbol_type want;
      bit         moved;
      moved = 1'b0;
      req_took <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         moved = 1'b1;
         got.line_level = rsp_bus.line_level;
         got.last_symbol = rsp_bus.last_symbol;
         if (expected_symbols.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected symbol transfer, actual level %b last %b",
                     $time, got.line_level, got.last_symbol);
         end else begin
            want = expected_symbols.pop_front();
            symbols_checked++;
            if (got.line_level !== want.line_level) begin
               mismatches++;
               $display("%0t: line_level expected %b actual %b",
                        $time, want.line_level, got.line_level);
            end
            if (got.last_symbol !== want.last_symbol) begin
               mismatches++;
               $display("%0t: last_symbol expected %b actual %b",
                        $time, want.last_symbol, got.last_symbol);
            end
         end
      end
      if (!reset && req_bus.valid && req_bus.ready) begin
         moved = 1'b1;
         chars_taken++;
         predict_frame(req_bus.data);
      end
      quiet_cycles = (moved || reset || csr_we) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout after %0d cycles without a transfer", QUIET_LIMIT);
         $display("uart_tx_frame_serializer_core verification failed");
         $finish;
      end
   end

   initial begin
      logic [1:0]        p;
      logic [HOLD_W-1:0] h;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      rsp_bus.ready = 1'b0;
      cfg_word_nine = 1'b0;
      cfg_parity = PAR_NONE;
      cfg_two_stop = 1'b0;
      cfg_hold = SYMBOL_CYCLES_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_char(9'h000);
      queue_char(9'h1FF);
      drain();

      apply_config(1'b1, PAR_NONE, 1'b1, 16'd1);
      queue_char(9'h100);
      queue_char(9'h0FF);
      queue_char(9'h155);
      queue_char(9'h0AA);
      drain();

      apply_config(1'b0, PAR_ODD, 1'b0, 16'd0);
      queue_char(9'h000);
      queue_char(9'h07F);
      queue_char(9'h001);
      queue_char(9'h180);
      drain();

      apply_config(1'b1, PAR_EVEN, 1'b1, 16'd2);
      queue_char(9'h000);
      queue_char(9'h0FF);
      queue_char(9'h001);
      queue_char(9'h1FF);
      drain();

      apply_config(1'b1, PAR_RESERVED, 1'b0, 16'd1);
      queue_char(9'h1FF);
      queue_char(9'h100);
      drain();

      apply_config(1'b0, PAR_NONE, 1'b0, 16'hFFFF);
      queue_char(9'h0A5);
      drain();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         p = 2'($urandom_range(0, 3));
         h = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(1, 4)) :
             16'($urandom_range(0, 12));
         apply_config(1'($urandom), p, 1'($urandom), h);
         no_idle = (ph % 4 == 1);
         for (int i = 0; i < CHARS_PER_PHASE; i++) begin
            queue_char(9'($urandom_range(0, 511)));
         end
         if (ph == 1) begin
            repeat (30) @(posedge clock);
            pressure_armed = 1;
         end
         drain();
      end
      no_idle = 0;

      $display("Sent %0d characters under %0d register settings, %0d line symbols compared.",
               chars_taken, settings_used, symbols_checked);
      $display("Covered 8 and 9 bit words, every parity selector, one and two stops,",
               " holds 0 to 65535.");
      if (mismatches == 0) begin
         $display("uart_tx_frame_serializer_core verification clean");
      end else begin
         $display("uart_tx_frame_serializer_core verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
